// ===== rtl/core/pose_to_egocentric_polar_core_macros.svh =====
// Assertion macros for the egocentric polar core.
`ifndef POSE_TO_EGOCENTRIC_POLAR_CORE_MACROS_SVH
`define POSE_TO_EGOCENTRIC_POLAR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTEP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PTEP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ptep_pkg.sv =====
// Shared types, constants and step functions for the egocentric polar core.
`default_nettype none

package ptep_pkg;

	localparam int unsigned POS_W    = 32;          // Q16.16 position
	localparam int unsigned ANG_W    = 16;          // binary angle
	localparam int unsigned DIFF_W   = POS_W + 1;   // exact position difference
	localparam int unsigned CW       = POS_W + 4;   // CORDIC x/y, covers gain growth
	localparam int unsigned Z_W      = 32;          // CORDIC angle accumulator
	localparam int unsigned SQ_W     = 2 * POS_W;   // squared length
	localparam int unsigned ROOT_W   = POS_W;       // root width
	localparam int unsigned SQRT_STEPS = ROOT_W;    // one root bit per stage

	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned CORDIC_STAGES_MAX = 32;

	localparam logic [POS_W-1:0] SMALL_RADIUS_RST = 32'd66;
	localparam logic [Z_W-1:0]   Z_HALF_TURN      = 32'h8000_0000;
	localparam logic [Z_W-1:0]   Z_ROUND          = 32'h0000_8000;

	// atan(2^-i), 2^32 = full turn
	localparam logic [Z_W-1:0] ATAN_LUT [CORDIC_STAGES_MAX] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic [POS_W-1:0] robot_x;
		logic [POS_W-1:0] robot_y;
		logic [ANG_W-1:0] robot_heading;
		logic [POS_W-1:0] target_x;
		logic [POS_W-1:0] target_y;
		logic [ANG_W-1:0] target_heading;
	} pose_t;

	typedef struct packed {
		logic [POS_W-1:0] range;
		logic [ANG_W-1:0] phi;
		logic [ANG_W-1:0] delta;
		logic [ANG_W-1:0] sight_angle;
	} polar_t;

	// word carried through the root / rotation stages
	typedef struct packed {
		logic [SQ_W-1:0]   rem;      // remainder of the square root
		logic [ROOT_W-1:0] root;     // root bits found so far
		logic              ovf;      // squared length above 64 bits
		logic [CW-1:0]     cx;       // CORDIC x, two's complement
		logic [CW-1:0]     cy;       // CORDIC y, two's complement
		logic [Z_W-1:0]    cz;       // CORDIC angle
		logic              zero;     // zero offset
		logic [ANG_W-1:0]  robot_heading;
		logic [ANG_W-1:0]  target_heading;
	} iter_t;

	typedef struct packed {
		logic head_valid;
		logic skid_valid;
	} obuf_stat_t;

	// one restoring square-root step for root bit j
	function automatic iter_t sqrt_step(iter_t w, int unsigned j);
		iter_t           r;
		logic [SQ_W:0]   trial;
		r = w;
		trial = ({{(SQ_W + 1 - ROOT_W){1'b0}}, w.root} << (j + 1))
			| ({{SQ_W{1'b0}}, 1'b1} << (2 * j));
		if ({1'b0, w.rem} >= trial) begin
			r.rem  = w.rem - trial[SQ_W-1:0];
			r.root = w.root | (ROOT_W'(1) << j);
		end
		return r;
	endfunction

	// one CORDIC vectoring micro-rotation, floor shifts, y >= 0 turns clockwise
	function automatic iter_t cordic_step(iter_t w, int unsigned i);
		iter_t                 r;
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [CW-1:0]  xs;
		logic signed [CW-1:0]  ys;
		r  = w;
		x  = $signed(w.cx);
		y  = $signed(w.cy);
		xs = x >>> i;
		ys = y >>> i;
		if (!y[CW-1]) begin
			r.cx = x + ys;
			r.cy = y - xs;
			r.cz = w.cz + ATAN_LUT[i[4:0]];
		end else begin
			r.cx = x - ys;
			r.cy = y + xs;
			r.cz = w.cz - ATAN_LUT[i[4:0]];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ptep_ifs.sv =====
// Valid/ready channel interfaces for pose words and polar result words.
`default_nettype none

interface ptep_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [15:0] robot_heading;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [15:0] target_heading;

	modport source (
		output valid, robot_x, robot_y, robot_heading,
		output target_x, target_y, target_heading,
		input  ready
	);
	modport sink (
		input  valid, robot_x, robot_y, robot_heading,
		input  target_x, target_y, target_heading,
		output ready
	);
endinterface

interface ptep_polar_if;
	logic               valid;
	logic               ready;
	logic        [31:0] range;
	logic signed [15:0] phi;
	logic signed [15:0] delta;
	logic signed [15:0] sight_angle;

	modport source (
		output valid, range, phi, delta, sight_angle,
		input  ready
	);
	modport sink (
		input  valid, range, phi, delta, sight_angle,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/ptep_front.sv =====
// Front stages: offsets, magnitudes, half-turn pre-rotation, squares and sum.
`default_nettype none

module ptep_front import ptep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  pose_t in_word,
	output logic  out_valid,
	output iter_t out_word
);

	logic v_s1, v_s2, v_s3, v_s4;

	// s1: exact differences
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [ANG_W-1:0]         rh_s1, th_s1;

	// s2: magnitudes and pre-rotated CORDIC vector
	logic [POS_W-1:0] ax_s2, ay_s2;
	logic [CW-1:0]    cx_s2, cy_s2;
	logic [Z_W-1:0]   cz_s2;
	logic             zero_s2;
	logic [ANG_W-1:0] rh_s2, th_s2;

	// s3: squares
	logic [SQ_W-1:0]  sx_s3, sy_s3;
	logic [CW-1:0]    cx_s3, cy_s3;
	logic [Z_W-1:0]   cz_s3;
	logic             zero_s3;
	logic [ANG_W-1:0] rh_s3, th_s3;

	// s4: sum
	iter_t word_s4;

	logic signed [DIFF_W-1:0] dx_neg, dy_neg;
	logic signed [CW-1:0]     dy_ext;
	logic [SQ_W-1:0]          sq_x, sq_y;
	logic [SQ_W:0]            sum;

	assign dx_neg = -dx_s1;
	assign dy_neg = -dy_s1;
	assign dy_ext = CW'(dy_s1);
	assign sq_x   = ax_s2 * ax_s2;
	assign sq_y   = ay_s2 * ay_s2;
	assign sum    = {1'b0, sx_s3} + {1'b0, sy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= $signed({in_word.target_x[POS_W-1], in_word.target_x})
				- $signed({in_word.robot_x[POS_W-1], in_word.robot_x});
			dy_s1 <= $signed({in_word.target_y[POS_W-1], in_word.target_y})
				- $signed({in_word.robot_y[POS_W-1], in_word.robot_y});
			rh_s1 <= in_word.robot_heading;
			th_s1 <= in_word.target_heading;

			ax_s2   <= dx_s1[DIFF_W-1] ? dx_neg[POS_W-1:0] : dx_s1[POS_W-1:0];
			ay_s2   <= dy_s1[DIFF_W-1] ? dy_neg[POS_W-1:0] : dy_s1[POS_W-1:0];
			// left half-plane: turn by pi so the CORDIC starts with x >= 0
			cx_s2   <= dx_s1[DIFF_W-1] ? CW'(dx_neg) : CW'(dx_s1);
			cy_s2   <= dx_s1[DIFF_W-1] ? -dy_ext : dy_ext;
			cz_s2   <= dx_s1[DIFF_W-1] ? Z_HALF_TURN : '0;
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			rh_s2   <= rh_s1;
			th_s2   <= th_s1;

			sx_s3   <= sq_x;
			sy_s3   <= sq_y;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			cz_s3   <= cz_s2;
			zero_s3 <= zero_s2;
			rh_s3   <= rh_s2;
			th_s3   <= th_s2;

			word_s4.rem            <= sum[SQ_W-1:0];
			word_s4.root           <= '0;
			word_s4.ovf            <= sum[SQ_W];
			word_s4.cx             <= cx_s3;
			word_s4.cy             <= cy_s3;
			word_s4.cz             <= cz_s3;
			word_s4.zero           <= zero_s3;
			word_s4.robot_heading  <= rh_s3;
			word_s4.target_heading <= th_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_word  = word_s4;

endmodule

`default_nettype wire

// ===== rtl/core/ptep_iter.sv =====
// Root and CORDIC stages: one root bit per stage, one micro-rotation in each of the first CORDIC_STAGES.
`default_nettype none

module ptep_iter import ptep_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  iter_t in_word,
	output logic  out_valid,
	output iter_t out_word
);

	logic [SQRT_STEPS-1:0] valid_s;
	iter_t                 word_s [SQRT_STEPS];
	iter_t                 nxt    [SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[SQRT_STEPS-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		iter_t prev;
		iter_t root_nxt;

		if (k == 0) begin : g_first
			assign prev = in_word;
		end else begin : g_next
			assign prev = word_s[k-1];
		end

		assign root_nxt = sqrt_step(prev, SQRT_STEPS - 1 - k);

		if (k < CORDIC_STAGES) begin : g_rot
			assign nxt[k] = cordic_step(root_nxt, k);
		end else begin : g_hold
			assign nxt[k] = root_nxt;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				word_s[k] <= nxt[k];
			end
		end
	end

	assign out_valid = valid_s[SQRT_STEPS-1];
	assign out_word  = word_s[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/ptep_back.sv =====
// Final select and heading differences, two-entry output buffer, stall control.
`default_nettype none

module ptep_back import ptep_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fin_valid,
	input  iter_t             fin_word,
	input  logic [POS_W-1:0]  small_radius,
	ptep_polar_if.source      polar,
	output logic              adv,
	output obuf_stat_t        stat
);

	polar_t head_q, skid_q, res;
	logic   head_valid_q, skid_valid_q;
	logic   push, pop;

	logic [Z_W-1:0]   z_rnd;
	logic [ANG_W-1:0] ang;
	logic [ANG_W-1:0] sight;
	logic [POS_W-1:0] rng;

	always_comb begin
		rng   = fin_word.ovf ? '1 : fin_word.root;
		z_rnd = fin_word.cz + Z_ROUND;
		ang   = fin_word.zero ? '0 : z_rnd[Z_W-1:Z_W-ANG_W];
		sight = (rng < small_radius) ? fin_word.target_heading : ang;
		res.range       = rng;
		res.sight_angle = sight;
		res.phi         = fin_word.target_heading - sight;
		res.delta       = fin_word.robot_heading - sight;
	end

	// stall only when a finished word meets a full buffer
	assign adv  = !(fin_valid && skid_valid_q);
	assign push = fin_valid && adv;
	assign pop  = head_valid_q && polar.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				head_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else begin
				head_valid_q <= head_valid_q || push;
				skid_valid_q <= skid_valid_q || (push && head_valid_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			head_q <= skid_q;
		end else if (push && (pop || !head_valid_q)) begin
			head_q <= res;
		end
		if (push && head_valid_q && !pop) begin
			skid_q <= res;
		end
	end

	assign polar.valid       = head_valid_q;
	assign polar.range       = head_q.range;
	assign polar.phi         = head_q.phi;
	assign polar.delta       = head_q.delta;
	assign polar.sight_angle = head_q.sight_angle;

	assign stat.head_valid = head_valid_q;
	assign stat.skid_valid = skid_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/pose_to_egocentric_polar_core.sv =====
// Top level: robot/target pose to range, sight angle, phi and delta.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+---------------------------------------------
//   pose     | in  | valid/ready      | robot x/y/heading, target x/y/heading
//   polar    | out | valid/ready      | range, phi, delta, sight_angle
//   cfg      | in  | cfg_we, no ready | small_radius (Q16.16)
//
// One word per cycle sustained while the output buffer has room; a word accepted at pose
// passes 4 front stages, 32 root stages (CORDIC rotations ride along in the first
// CORDIC_STAGES of them) and the output register before it can be taken at polar.
// arst_n clears all valid bits and the buffer; small_radius resets to 66.
// The pipe stalls as a whole only when its last stage holds a word and both
// output buffer entries are full; pose.ready is that stall, low for no other reason.
`default_nettype none

`include "pose_to_egocentric_polar_core_macros.svh"

module pose_to_egocentric_polar_core import ptep_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata,
	ptep_pose_if.sink        pose,
	ptep_polar_if.source     polar
);

	logic [POS_W-1:0] small_radius_q;

	logic       adv;
	pose_t      pose_word;
	logic       front_valid;
	iter_t      front_word;
	logic       iter_valid;
	iter_t      iter_word;
	obuf_stat_t stat;

	// threshold register; to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_radius_q <= SMALL_RADIUS_RST;
		end else if (cfg_we) begin
			small_radius_q <= cfg_wdata;
		end
	end

	assign pose.ready = adv;

	assign pose_word.robot_x        = pose.robot_x;
	assign pose_word.robot_y        = pose.robot_y;
	assign pose_word.robot_heading  = pose.robot_heading;
	assign pose_word.target_x       = pose.target_x;
	assign pose_word.target_y       = pose.target_y;
	assign pose_word.target_heading = pose.target_heading;

	// offsets, magnitudes, squares, squared length
	ptep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pose.valid),
		.in_word   (pose_word),
		.out_valid (front_valid),
		.out_word  (front_word)
	);

	// square root and CORDIC vectoring side by side
	ptep_iter #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (front_valid),
		.in_word   (front_word),
		.out_valid (iter_valid),
		.out_word  (iter_word)
	);

	// near-target select, heading differences, output buffer
	ptep_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fin_valid    (iter_valid),
		.fin_word     (iter_word),
		.small_radius (small_radius_q),
		.polar        (polar),
		.adv          (adv),
		.stat         (stat)
	);

	`PTEP_ASSERT_IMP(a_skid_needs_head, stat.skid_valid, stat.head_valid, "skid without head")
	`PTEP_ASSERT_IMP(a_stall_only_full, !pose.ready, stat.head_valid && stat.skid_valid, "early stall")
	`PTEP_ASSERT_NXT(a_stall_keeps_last, iter_valid && !adv, iter_valid, "stalled word dropped")

endmodule

`default_nettype wire

// ===== tb/polar_checker.sv =====
// Checker for the egocentric polar core: predicts each polar word and compares.
`timescale 1ns / 1ps

module polar_checker import ptep_pkg::*; #(
	parameter int unsigned ROTATIONS = CORDIC_STAGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata,
	ptep_pose_if             pose,
	ptep_polar_if            polar,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);

	// atan(2^-i), full turn = 2^32
	localparam logic [31:0] ARCTAN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	logic [POS_W-1:0] radius;
	polar_t           expected_polar [$];

	function automatic polar_t egocentric_polar(pose_t p, logic [31:0] thr);
		longint      dx;
		longint      dy;
		longint      cx;
		longint      cy;
		longint      xs;
		longint      ys;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [64:0] len_sq;
		logic [31:0] root;
		logic [63:0] trial;
		logic [31:0] turn;
		logic [31:0] rounded;
		logic [15:0] sight;
		polar_t      res;
		dx = longint'($signed(p.target_x)) - longint'($signed(p.robot_x));
		dy = longint'($signed(p.target_y)) - longint'($signed(p.robot_y));
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		len_sq = {1'b0, ax * ax} + {1'b0, ay * ay};
		// floor square root, saturated when the square sum leaves 64 bits
		if (len_sq[64]) begin
			root = 32'hFFFF_FFFF;
		end else begin
			root = '0;
			for (int j = 31; j >= 0; j--) begin
				trial = {32'd0, root | (32'd1 << j)};
				if (trial * trial <= len_sq[63:0])
					root = trial[31:0];
			end
		end
		if (root < thr) begin
			sight = p.target_heading;
		end else if (dx == 0 && dy == 0) begin
			sight = '0;
		end else begin
			cx = dx;
			cy = dy;
			turn = '0;
			if (cx < 0) begin
				cx = -cx;
				cy = -cy;
				turn = 32'h8000_0000;
			end
			for (int i = 0; i < ROTATIONS && i < 32; i++) begin
				xs = cx >>> i;
				ys = cy >>> i;
				if (cy >= 0) begin
					cx = cx + ys;
					cy = cy - xs;
					turn = turn + ARCTAN[i[4:0]];
				end else begin
					cx = cx - ys;
					cy = cy + xs;
					turn = turn - ARCTAN[i[4:0]];
				end
			end
			rounded = turn + 32'h0000_8000;
			sight = rounded[31:16];
		end
		res.range       = root;
		res.phi         = p.target_heading - sight;
		res.delta       = p.robot_heading - sight;
		res.sight_angle = sight;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		polar_t got;
		polar_t want;
		pose_t  w;
		if (!arst_n) begin
			radius <= SMALL_RADIUS_RST;
			expected_polar.delete();
			outstanding <= 0;
			mismatches = 0;
		end else begin
			if (cfg_we)
				radius <= cfg_wdata;
			// check first: a word accepted now cannot answer a pose accepted now
			if (polar.valid && polar.ready) begin
				got.range       = polar.range;
				got.phi         = polar.phi;
				got.delta       = polar.delta;
				got.sight_angle = polar.sight_angle;
				if (expected_polar.size() == 0) begin
					$display("%0t: unexpected polar word %h", $time, got);
					mismatches = mismatches + 1;
				end else begin
					want = expected_polar.pop_front();
					if (got.range !== want.range) begin
						$display("%0t: range expected %h actual %h", $time,
							want.range, got.range);
						mismatches = mismatches + 1;
					end
					if (got.phi !== want.phi) begin
						$display("%0t: phi expected %h actual %h", $time,
							want.phi, got.phi);
						mismatches = mismatches + 1;
					end
					if (got.delta !== want.delta) begin
						$display("%0t: delta expected %h actual %h", $time,
							want.delta, got.delta);
						mismatches = mismatches + 1;
					end
					if (got.sight_angle !== want.sight_angle) begin
						$display("%0t: sight_angle expected %h actual %h", $time,
							want.sight_angle, got.sight_angle);
						mismatches = mismatches + 1;
					end
				end
			end
			if (pose.valid && pose.ready) begin
				w.robot_x        = pose.robot_x;
				w.robot_y        = pose.robot_y;
				w.robot_heading  = pose.robot_heading;
				w.target_x       = pose.target_x;
				w.target_y       = pose.target_y;
				w.target_heading = pose.target_heading;
				expected_polar.push_back(egocentric_polar(w, radius));
			end
			outstanding <= expected_polar.size();
		end
	end

endmodule

// ===== tb/pose_to_egocentric_polar_core_tb.sv =====
// Testbench top: pose stimulus, result-side back-pressure and the final verdict.
`timescale 1ns / 1ps

module pose_to_egocentric_polar_core_tb;
	import ptep_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;  // watchdog bound on the whole run
	localparam int unsigned PHASE_WORDS = 300;     // random words per radius setting
	localparam int unsigned HOLD_AT     = 500;     // words in before the long hold-off
	localparam int unsigned HOLD_CYCLES = 300;     // far more than pipe + buffer depth
	localparam int unsigned DRAIN       = 60;      // extra wait after the final settle
	localparam logic [31:0] CORNERS [4] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [POS_W-1:0] cfg_wdata;
	int unsigned      mismatches;
	int unsigned      outstanding;
	int unsigned      words_in;
	int unsigned      cycle_count;
	bit               calm;        // no idling on either side while set

	ptep_pose_if  pose_ch ();
	ptep_polar_if polar_ch ();

	pose_to_egocentric_polar_core #(
		.CORDIC_STAGES(CORDIC_STAGES_DEF)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pose     (pose_ch),
		.polar    (polar_ch)
	);

	polar_checker #(
		.ROTATIONS(CORDIC_STAGES_DEF)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pose       (pose_ch),
		.polar      (polar_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic pose_t pose_word(logic [31:0] rx, logic [31:0] ry, logic [15:0] rh,
		logic [31:0] tx, logic [31:0] ty, logic [15:0] th);
		pose_t p;
		p.robot_x        = rx;
		p.robot_y        = ry;
		p.robot_heading  = rh;
		p.target_x       = tx;
		p.target_y       = ty;
		p.target_heading = th;
		return p;
	endfunction

	// Mix of offsets: wide random, near the small-radius threshold at several
	// scales, shifted magnitudes, zero offset and the position corners.
	function automatic pose_t random_pose();
		pose_t       p;
		int unsigned k;
		logic [31:0] mask;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2: begin
			end
			3, 4, 5: begin
				case ($urandom_range(2))
					0:       k = 80;
					1:       k = 3000;
					default: k = 200000;
				endcase
				p.target_x = p.robot_x + 32'(int'($urandom_range(2 * k)) - int'(k));
				p.target_y = p.robot_y + 32'(int'($urandom_range(2 * k)) - int'(k));
			end
			6, 7: begin
				mask = {32{1'($urandom_range(1))}};
				p.target_x = p.robot_x + (($urandom >> $urandom_range(31)) ^ mask);
				mask = {32{1'($urandom_range(1))}};
				p.target_y = p.robot_y + (($urandom >> $urandom_range(31)) ^ mask);
			end
			8: begin
				p.target_x = p.robot_x;
				p.target_y = p.robot_y;
			end
			default: begin
				p.robot_x  = CORNERS[2'($urandom_range(3))];
				p.robot_y  = CORNERS[2'($urandom_range(3))];
				p.target_x = CORNERS[2'($urandom_range(3))];
				p.target_y = CORNERS[2'($urandom_range(3))];
			end
		endcase
		if ($urandom_range(7) == 0)
			p.robot_heading = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		if ($urandom_range(7) == 0)
			p.target_heading = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		return p;
	endfunction

	// Present one word, hold it until taken, then maybe idle for a random gap.
	// valid is only lowered when a gap follows, so it never toggles within a step.
	task automatic offer(pose_t w);
		pose_ch.robot_x        <= w.robot_x;
		pose_ch.robot_y        <= w.robot_y;
		pose_ch.robot_heading  <= w.robot_heading;
		pose_ch.target_x       <= w.target_x;
		pose_ch.target_y       <= w.target_y;
		pose_ch.target_heading <= w.target_heading;
		pose_ch.valid          <= 1'b1;
		do @(posedge clk); while (!pose_ch.ready);
		words_in = words_in + 1;
		if (!calm && $urandom_range(99) < 27) begin
			pose_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 27);
		end
	endtask

	// Stop offering and wait for every predicted word to come out.
	task automatic settle();
		pose_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// small_radius only changes while the pipe is empty
	task automatic write_radius(logic [31:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Result side: random ready, one long hold-off once enough words went in so
	// the pipe and its output buffer fill and pose.ready drops.
	initial begin : sink_side
		bit held_off;
		held_off = 1'b0;
		polar_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && words_in >= HOLD_AT) begin
				held_off = 1'b1;
				polar_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			polar_ch.ready <= calm || ($urandom_range(99) >= 27);
		end
	end

	initial begin : source_side
		logic [31:0] radius_plan [6];
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		calm                   = 1'b0;
		words_in               = 0;
		pose_ch.valid          = 1'b0;
		pose_ch.robot_x        = '0;
		pose_ch.robot_y        = '0;
		pose_ch.robot_heading  = '0;
		pose_ch.target_x       = '0;
		pose_ch.target_y       = '0;
		pose_ch.target_heading = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset radius (66) ---
		// zero offset: heading replaces the angle, heading extremes
		offer(pose_word('0, '0, 16'h8000, '0, '0, 16'h7FFF));
		// largest +dx: range exactly at the top of the field
		offer(pose_word(32'h8000_0000, '0, 16'h7FFF, 32'h7FFF_FFFF, '0, 16'h8000));
		// both offsets largest: square sum overflows, range saturates
		offer(pose_word(32'h8000_0000, 32'h8000_0000, '0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
		// largest -dx: half-turn pre-rotation
		offer(pose_word(32'h7FFF_FFFF, '0, '0, 32'h8000_0000, '0, 16'h1234));
		offer(pose_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000,
			32'h8000_0000, 32'h8000_0000, 16'h8000));
		offer(pose_word(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF,
			32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF));
		// axis directions
		offer(pose_word('0, '0, '0, '0, 32'h0010_0000, '0));
		offer(pose_word('0, '0, '0, '0, 32'hFFF0_0000, '0));
		offer(pose_word('0, '0, '0, 32'hFFFF_0000, '0, '0));
		offer(pose_word('0, '0, '0, 32'hFFFF_0000, 32'h0000_0001, '0));
		offer(pose_word('0, '0, '0, 32'hFFFF_0000, 32'hFFFF_FFFF, '0));
		// around the threshold: 65 below, 66 not below
		offer(pose_word(32'd100, 32'd100, 16'h4000, 32'd165, 32'd100, 16'hC000));
		offer(pose_word(32'd100, 32'd100, 16'h4000, 32'd166, 32'd100, 16'hC000));
		offer(pose_word(32'd100, 32'd100, 16'h2000, 32'd146, 32'd147, 16'hE000));
		offer(pose_word(32'd100, 32'd100, 16'h2000, 32'd147, 32'd147, 16'hE000));
		offer(pose_word(32'h1234_5678, 32'hFEDC_BA98, 16'h5A5A,
			32'h0BAD_F00D, 32'h7654_3210, 16'hA5A5));
		offer(pose_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, '0, '0, 16'h8000));
		offer(pose_word('0, '0, 16'h8000, 32'h0001_0000, 32'h0001_0000, 16'h8000));

		// radius zero: zero offset gives angle 0
		write_radius(32'd0);
		offer(pose_word(32'h0042_0000, 32'hFFC0_0000, 16'h7FFF,
			32'h0042_0000, 32'hFFC0_0000, 16'h8001));
		offer(pose_word('0, '0, 16'h0100, 32'd1, '0, 16'hFF00));

		// radius at its top: only a range at its top value (saturated or exact) escapes the heading path
		write_radius(32'hFFFF_FFFF);
		offer(pose_word(32'h8000_0000, 32'h8000_0000, 16'h1111,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2222));
		offer(pose_word(32'h8000_0000, '0, 16'h3333, 32'h7FFF_FFFF, '0, 16'h4444));
		offer(pose_word(32'h0100_0000, 32'h0200_0000, 16'h5555,
			32'hF000_0000, 32'h0300_0000, 16'h6666));

		// --- random phases, one radius setting each ---
		radius_plan = '{32'd66, 32'hFFFF_FFFF, 32'd0, 32'($urandom_range(1, 300000)),
			32'h0001_0000, 32'($urandom)};
		for (int ph = 0; ph < 6; ph++) begin
			write_radius(radius_plan[3'(ph)]);
			calm = (ph == 2);
			repeat (PHASE_WORDS) offer(random_pose());
		end
		calm = 1'b0;

		settle();
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
